@@ sv/uapq_pkg.sv @@
package uapq_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_PEEK   = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int FILL_W  = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_WAIT,
    S_SHIFT_SET,
    S_SHIFT,
    S_SHIFT_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       ins_write;
    logic       set_res;
    logic [1:0] res_code;
    logic       res_best;
    logic       scan_start;
    logic       scan_step;
    logic       shift_start;
    logic       shift_step;
    logic       count_dec;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty;
    logic       idx_last;
    logic       out_free;
  } stat_t;

endpackage

@@ sv/uapq_ctrl.sv @@
module uapq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  uapq_pkg::stat_t  stat,
  output uapq_pkg::cmd_t   cmd
);

  uapq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uapq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = rst | (state != uapq_pkg::S_IDLE);
    case (state)
      uapq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = uapq_pkg::S_DECODE;
        end
      end
      uapq_pkg::S_DECODE: begin
        cmd.set_res = 1'b1;
        cmd.res_code = uapq_pkg::STATUS_OK;
        state_next = uapq_pkg::S_DONE;
        case (stat.func)
          uapq_pkg::FUNC_INSERT: begin
            if (stat.full) begin
              cmd.res_code = uapq_pkg::STATUS_FULL;
            end else begin
              cmd.ins_write = 1'b1;
            end
          end
          uapq_pkg::FUNC_PEEK, uapq_pkg::FUNC_DELETE: begin
            if (stat.empty) begin
              cmd.res_code = uapq_pkg::STATUS_EMPTY;
            end else begin
              cmd.res_best   = 1'b1;
              cmd.scan_start = 1'b1;
              state_next     = uapq_pkg::S_SCAN;
            end
          end
          default: begin
            // unused code: no operation
          end
        endcase
      end
      uapq_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.idx_last) begin
          state_next = uapq_pkg::S_SCAN_WAIT;
        end
      end
      uapq_pkg::S_SCAN_WAIT: begin
        if (stat.func == uapq_pkg::FUNC_DELETE) begin
          state_next = uapq_pkg::S_SHIFT_SET;
        end else begin
          state_next = uapq_pkg::S_DONE;
        end
      end
      uapq_pkg::S_SHIFT_SET: begin
        cmd.shift_start = 1'b1;
        state_next      = uapq_pkg::S_SHIFT;
      end
      uapq_pkg::S_SHIFT: begin
        if (stat.idx_last) begin
          state_next = uapq_pkg::S_SHIFT_WAIT;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      uapq_pkg::S_SHIFT_WAIT: begin
        cmd.count_dec = 1'b1;
        state_next    = uapq_pkg::S_DONE;
      end
      uapq_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = uapq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = uapq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/uapq_dp.sv @@
module uapq_dp #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [1:0]                           func,
  input  logic signed [uapq_pkg::VALUE_W-1:0]  item_value,
  input  logic [uapq_pkg::PRIO_W-1:0]          item_priority,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [uapq_pkg::VALUE_W-1:0]  out_value,
  output logic [1:0]                           status,
  output logic [uapq_pkg::FILL_W-1:0]          fill_level,
  input  uapq_pkg::cmd_t                       cmd,
  output uapq_pkg::stat_t                      stat
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = uapq_pkg::PRIO_W + uapq_pkg::VALUE_W;

  // entry store: priority in the upper bits, value in the lower bits
  logic [MW-1:0] mem [QUEUE_DEPTH];

  logic [1:0]                          op_func;
  logic [uapq_pkg::VALUE_W-1:0]        op_value;
  logic [uapq_pkg::PRIO_W-1:0]         op_prio;
  logic [CW-1:0]                       count;
  logic [AW-1:0]                       idx;
  logic [AW-1:0]                       best_idx;
  logic [uapq_pkg::PRIO_W-1:0]         best_prio;
  logic [uapq_pkg::VALUE_W-1:0]        best_val;
  logic [1:0]                          res_status;
  logic                                res_best;

  logic [MW-1:0]   rd_data;
  logic [AW-1:0]   rd_idx;
  logic            rd_ok;
  logic            rd_shift;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [MW-1:0]   wr_data;
  logic            take_best;

  always_comb begin
    rd_en   = cmd.scan_step | cmd.shift_step;
    rd_addr = cmd.shift_step ? AW'(idx + AW'(1)) : idx;
    wr_en   = cmd.ins_write | (rd_ok & rd_shift);
    if (cmd.ins_write) begin
      wr_addr = count[AW-1:0];
      wr_data = {op_prio, op_value};
    end else begin
      wr_addr = AW'(rd_idx - AW'(1));
      wr_data = rd_data;
    end
    take_best = rd_ok & ~rd_shift &
                ((rd_idx == '0) | (rd_data[MW-1 -: uapq_pkg::PRIO_W] > best_prio));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_ok     <= 1'b0;
      rd_shift  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_ok    <= rd_en;
      rd_shift <= cmd.shift_step;
      if (cmd.ins_write) begin
        count <= CW'(count + CW'(1));
      end else if (cmd.count_dec) begin
        count <= CW'(count - CW'(1));
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    if (cmd.load) begin
      op_func  <= func;
      op_value <= item_value;
      op_prio  <= item_priority;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_best   <= cmd.res_best;
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.shift_start) begin
      idx <= best_idx;
    end else if (rd_en) begin
      idx <= AW'(idx + AW'(1));
    end
    if (take_best) begin
      best_idx  <= rd_idx;
      best_prio <= rd_data[MW-1 -: uapq_pkg::PRIO_W];
      best_val  <= rd_data[uapq_pkg::VALUE_W-1:0];
    end
    if (cmd.out_load) begin
      out_value  <= res_best ? best_val : '0;
      status     <= res_status;
      fill_level <= uapq_pkg::FILL_W'(count);
    end
  end

  always_comb begin
    stat.func     = op_func;
    stat.full     = (count == CW'(QUEUE_DEPTH));
    stat.empty    = (count == '0);
    stat.idx_last = (CW'(idx) == CW'(count - CW'(1)));
    stat.out_free = ~out_valid | ~out_stall;
  end

endmodule

@@ sv/unsorted_array_priority_queue.sv @@
// bounded priority queue of (value, priority) pairs kept in arrival order
//
// input channel: func, item_value, item_priority with in_valid / in_stall;
// a beat is taken when in_valid is high and in_stall is low. func selects
// insert, peek highest or delete highest. output channel: out_value,
// status, fill_level with out_valid / out_stall, one result beat per input.
//
// insert and the unused code go from decode straight to the result; peek
// walks the held entries once to scan for the highest priority, and delete
// walks them once to scan and once more from the removed slot to shift the
// later entries down. in_stall is high while an operation is in flight, so
// the next beat waits until the result is handed to the output register.
//
// the result sits in an output register, so the next beat is accepted while
// a finished result is still stalled; that next result waits in its final
// state until the output register is free.
//
// reset empties the queue (count to zero), drops any pending result and holds
// in_stall high; the entry store is not cleared, only slots below the count are read
module unsorted_array_priority_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          func,
  input  logic signed [uapq_pkg::VALUE_W-1:0] item_value,
  input  logic [uapq_pkg::PRIO_W-1:0]         item_priority,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [uapq_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                          status,
  output logic [uapq_pkg::FILL_W-1:0]         fill_level
);

  uapq_pkg::cmd_t  cmd;
  uapq_pkg::stat_t stat;

  // sequencer: decode, scan, shift and result hand-off
  uapq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry store, count, best-so-far tracking and output register
  uapq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .func          (func),
    .item_value    (item_value),
    .item_priority (item_priority),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .status        (status),
    .fill_level    (fill_level),
    .cmd           (cmd),
    .stat          (stat)
  );

`ifndef NO_ASSERTIONS
  // an insert never writes into a full queue
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> !stat.full)
    else $error("insert write while queue full");

  // a new result never overwrites one still stalled at the output
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over a stalled beat");

  // a result beat only appears after the sequencer loaded it
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

  // the queue cannot be full and empty at once
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("queue count inconsistent");
`endif

endmodule

@@ sim/unsorted_array_priority_queue_test.sv @@
module unsorted_array_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 8;

  // the package names three operations; the fourth code is a no-op
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic signed [uapq_pkg::VALUE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [uapq_pkg::VALUE_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;
  localparam logic [uapq_pkg::PRIO_W-1:0] TOP_PRIO = 16'hffff;

  // cycles the receiver refuses results during the back-pressure phase
  localparam int HOLD_OFF_CYCLES = 300;
  // drain time after the last result, above the worst delete latency
  localparam int DRAIN_CYCLES = 40;

  // one result beat as the block should present it
  typedef struct {
    logic signed [uapq_pkg::VALUE_W-1:0] value;
    logic [1:0]                          status;
    logic [uapq_pkg::FILL_W-1:0]         fill;
  } queue_result_t;

  // one row of the directed table; a typed row carries its own answer
  typedef struct {
    logic [1:0]                          op;
    logic signed [uapq_pkg::VALUE_W-1:0] value;
    logic [uapq_pkg::PRIO_W-1:0]         prio;
    bit                                  typed;
    queue_result_t                       want;
  } stimulus_row_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [1:0]                          func = uapq_pkg::FUNC_INSERT;
  logic signed [uapq_pkg::VALUE_W-1:0] item_value = '0;
  logic [uapq_pkg::PRIO_W-1:0]         item_priority = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [uapq_pkg::VALUE_W-1:0] out_value;
  logic [1:0]                          status;
  logic [uapq_pkg::FILL_W-1:0]         fill_level;

  // mirror of the queue contents, oldest entry at index zero
  logic signed [uapq_pkg::VALUE_W-1:0] held_value [QUEUE_DEPTH];
  logic [uapq_pkg::PRIO_W-1:0]         held_prio [QUEUE_DEPTH];
  int                                  held_count = 0;

  queue_result_t pending_results[$];
  stimulus_row_t directed_rows[$];
  queue_result_t front_want;
  int            error_count = 0;

  // idling knobs: percent of cycles the sender idles / the receiver stalls
  int idle_pct = 0;
  int stall_pct = 0;

  // back-pressure request: the sender bumps the token, the receiver counts
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  unsorted_array_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .item_value   (item_value),
    .item_priority(item_priority),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .status       (status),
    .fill_level   (fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one accepted operation to the mirror and return its result beat;
  // the scan takes the first strictly greater priority, so the oldest wins
  // on a tie, and priority zero is scanned like any other
  function automatic queue_result_t apply_queue_op(
    input logic [1:0]                          op,
    input logic signed [uapq_pkg::VALUE_W-1:0] v,
    input logic [uapq_pkg::PRIO_W-1:0]         p
  );
    queue_result_t r;
    int            best;
    int            k;
    r.value  = '0;
    r.status = uapq_pkg::STATUS_OK;
    case (op)
      uapq_pkg::FUNC_INSERT: begin
        if (held_count >= QUEUE_DEPTH) begin
          r.status = uapq_pkg::STATUS_FULL;
        end else begin
          held_value[held_count] = v;
          held_prio[held_count]  = p;
          held_count++;
        end
      end
      uapq_pkg::FUNC_PEEK, uapq_pkg::FUNC_DELETE: begin
        if (held_count == 0) begin
          r.status = uapq_pkg::STATUS_EMPTY;
        end else begin
          best = 0;
          for (k = 1; k < held_count; k++) begin
            if (held_prio[k] > held_prio[best]) best = k;
          end
          r.value = held_value[best];
          if (op == uapq_pkg::FUNC_DELETE) begin
            // close the gap: later entries move down one slot
            for (k = best; k + 1 < held_count; k++) begin
              held_value[k] = held_value[k+1];
              held_prio[k]  = held_prio[k+1];
            end
            held_count--;
          end
        end
      end
      default: ;
    endcase
    r.fill = held_count[uapq_pkg::FILL_W-1:0];
    return r;
  endfunction

  task automatic add_row(input logic [1:0] op,
                         input logic signed [uapq_pkg::VALUE_W-1:0] v,
                         input logic [uapq_pkg::PRIO_W-1:0] p, input bit typed,
                         input logic signed [uapq_pkg::VALUE_W-1:0] want_value,
                         input logic [1:0] want_status, input int want_fill);
    stimulus_row_t row;
    row.op          = op;
    row.value       = v;
    row.prio        = p;
    row.typed       = typed;
    row.want.value  = want_value;
    row.want.status = want_status;
    row.want.fill   = want_fill[uapq_pkg::FILL_W-1:0];
    directed_rows.push_back(row);
  endtask

  // present one beat, with random idle cycles ahead of it, and return in
  // the time step of the edge that took it; the payload holds while stalled
  task automatic offer_beat(input logic [1:0] op,
                            input logic signed [uapq_pkg::VALUE_W-1:0] v,
                            input logic [uapq_pkg::PRIO_W-1:0] p);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= op;
    item_value    <= v;
    item_priority <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // random traffic in fill-heavy and drain-heavy stretches, so the queue
  // keeps running between empty and full and both error cases come up
  task automatic run_random(input int idle, input int stall, input int count);
    int                                  n;
    int                                  roll;
    int                                  pick;
    bit                                  fill_heavy;
    logic [1:0]                          op;
    logic signed [uapq_pkg::VALUE_W-1:0] v;
    logic [uapq_pkg::PRIO_W-1:0]         p;
    fill_heavy = ($urandom_range(0, 1) != 0);
    idle_pct   = idle;
    stall_pct <= stall;
    for (n = 0; n < count; n++) begin
      if (n % 30 == 0) fill_heavy = !fill_heavy;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = FUNC_UNUSED;
      end else if (roll < (fill_heavy ? 70 : 25)) begin
        op = uapq_pkg::FUNC_INSERT;
      end else if (roll < (fill_heavy ? 82 : 60)) begin
        op = uapq_pkg::FUNC_PEEK;
      end else begin
        op = uapq_pkg::FUNC_DELETE;
      end
      v = $urandom;
      // narrow priorities make ties common, the rest spread over the range
      case ($urandom_range(0, 3))
        0: begin
          pick = $urandom_range(0, 3);
          p    = pick[uapq_pkg::PRIO_W-1:0];
        end
        1: p = $urandom_range(0, 1) ? TOP_PRIO : '0;
        default: begin
          pick = $urandom_range(0, 65535);
          p    = pick[uapq_pkg::PRIO_W-1:0];
        end
      endcase
      offer_beat(op, v, p);
      pending_results.push_back(apply_queue_op(op, v, p));
    end
  endtask

  // receiver: random stall, or a long hold-off when the sender asks for one
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker: every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: value %0d status %0d fill %0d",
                 $realtime, out_value, status, fill_level);
        error_count++;
      end else begin
        front_want = pending_results.pop_front();
        if (out_value !== front_want.value) begin
          $display("%0t: out_value mismatch: expected %0d actual %0d",
                   $realtime, front_want.value, out_value);
          error_count++;
        end
        if (status !== front_want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $realtime, front_want.status, status);
          error_count++;
        end
        if (fill_level !== front_want.fill) begin
          $display("%0t: fill_level mismatch: expected %0d actual %0d",
                   $realtime, front_want.fill, fill_level);
          error_count++;
        end
      end
    end
  end

  initial begin
    int            n;
    stimulus_row_t row;
    queue_result_t r;

    // directed table: empty queue errors, the no-op code, value and
    // priority extremes, a fill to full with a rejected insert, then a
    // drain that shows tie order and priority zero taking part
    add_row(uapq_pkg::FUNC_PEEK, '0, '0, 1'b1, '0, uapq_pkg::STATUS_EMPTY, 0);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, '0, uapq_pkg::STATUS_EMPTY, 0);
    add_row(FUNC_UNUSED, 32'sh1234_5678, 16'h1234, 1'b1, '0, uapq_pkg::STATUS_OK, 0);
    add_row(uapq_pkg::FUNC_INSERT, MOST_NEGATIVE, '0, 1'b1, '0, uapq_pkg::STATUS_OK, 1);
    add_row(uapq_pkg::FUNC_PEEK, '0, '0, 1'b1, MOST_NEGATIVE, uapq_pkg::STATUS_OK, 1);
    add_row(uapq_pkg::FUNC_INSERT, MOST_POSITIVE, TOP_PRIO, 1'b1, '0,
            uapq_pkg::STATUS_OK, 2);
    add_row(uapq_pkg::FUNC_INSERT, 32'sh5a5a_5a5a, TOP_PRIO, 1'b1, '0,
            uapq_pkg::STATUS_OK, 3);
    add_row(uapq_pkg::FUNC_INSERT, -32'sd1, 16'h0001, 1'b1, '0, uapq_pkg::STATUS_OK, 4);
    add_row(uapq_pkg::FUNC_INSERT, 32'sd123, TOP_PRIO, 1'b1, '0, uapq_pkg::STATUS_OK, 5);
    add_row(uapq_pkg::FUNC_INSERT, 32'sd7, '0, 1'b1, '0, uapq_pkg::STATUS_OK, 6);
    add_row(uapq_pkg::FUNC_INSERT, -32'sd7, 16'h8000, 1'b1, '0, uapq_pkg::STATUS_OK, 7);
    add_row(uapq_pkg::FUNC_INSERT, 32'sd42, TOP_PRIO, 1'b1, '0, uapq_pkg::STATUS_OK, 8);
    add_row(uapq_pkg::FUNC_INSERT, 32'sd99, TOP_PRIO, 1'b1, '0, uapq_pkg::STATUS_FULL, 8);
    add_row(FUNC_UNUSED, '0, '0, 1'b1, '0, uapq_pkg::STATUS_OK, 8);
    add_row(uapq_pkg::FUNC_PEEK, '0, '0, 1'b1, MOST_POSITIVE, uapq_pkg::STATUS_OK, 8);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, MOST_POSITIVE, uapq_pkg::STATUS_OK, 7);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, 32'sh5a5a_5a5a, uapq_pkg::STATUS_OK, 6);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, 32'sd123, uapq_pkg::STATUS_OK, 5);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, 32'sd42, uapq_pkg::STATUS_OK, 4);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, -32'sd7, uapq_pkg::STATUS_OK, 3);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, -32'sd1, uapq_pkg::STATUS_OK, 2);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, MOST_NEGATIVE, uapq_pkg::STATUS_OK, 1);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, 32'sd7, uapq_pkg::STATUS_OK, 0);
    add_row(uapq_pkg::FUNC_DELETE, '0, '0, 1'b1, '0, uapq_pkg::STATUS_EMPTY, 0);
    // the rest of the rows go through the predictor
    add_row(uapq_pkg::FUNC_INSERT, 32'sh0a5a_a5a5, 16'h5aa5, 1'b0, '0,
            uapq_pkg::STATUS_OK, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < directed_rows.size(); n++) begin
      row = directed_rows[n];
      offer_beat(row.op, row.value, row.prio);
      r = apply_queue_op(row.op, row.value, row.prio);
      pending_results.push_back(row.typed ? row.want : r);
    end

    // idling phases: none, sender idle, receiver stalling, both
    run_random(0, 0, 205);
    run_random(88, 0, 205);
    run_random(0, 88, 205);
    run_random(22, 22, 205);

    // back-pressure: receiver holds off while the sender keeps offering,
    // so the output register and the finished slot fill and in_stall rises
    hold_token <= hold_token + 1;
    run_random(0, 0, 30);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("unsorted_array_priority_queue regression: pass");
    end else begin
      $display("unsorted_array_priority_queue regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("unsorted_array_priority_queue regression: fail");
    $finish;
  end

endmodule
